// ----- hw/rtl/manchester_frame_transmitter_defines.svh -----
// Assertion macros used by the frame sequencer of the Manchester frame transmitter.
`ifndef MANCHESTER_FRAME_TRANSMITTER_DEFINES_SVH
`define MANCHESTER_FRAME_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MFT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mft assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mft assertion failed");

`endif

// ----- hw/rtl/mft_pkg.sv -----
// Package with the types and constants of the Manchester frame transmitter.
package mft_pkg;

   localparam int unsigned DataW     = 8;
   localparam int unsigned CfgW      = 4;
   localparam int unsigned CsrIndexW = 2;
   localparam int unsigned CsrDataW  = 8;
   localparam int unsigned CntW      = 4;

   localparam logic [CfgW-1:0] PreamblePairsReset = 4'd5;
   localparam logic [CfgW-1:0] SyncSlotsReset     = 4'd6;
   localparam logic [CntW-1:0] DataBitCount       = 4'd8;

   localparam logic [CsrIndexW-1:0] CSR_PREAMBLE_PAIRS = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_SYNC_SLOTS     = 2'd1;

   typedef enum logic [1:0] {
      CNT_PRE  = 2'd0,
      CNT_SYNC = 2'd1,
      CNT_BITS = 2'd2
   } cnt_src_type;

   typedef enum logic [1:0] {
      LVL_LOW  = 2'd0,
      LVL_HIGH = 2'd1,
      LVL_BIT  = 2'd2,
      LVL_NBIT = 2'd3
   } lvl_src_type;

   typedef struct packed {
      logic        load_byte;
      logic        cnt_load;
      cnt_src_type cnt_src;
      logic        cnt_dec;
      logic        shift;
      logic        emit;
      lvl_src_type lvl_src;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic cnt_last;
      logic pre_zero;
      logic sync_zero;
   } status_type;

endpackage

// ----- hw/rtl/manchester_frame_transmitter.sv -----
// Manchester frame transmitter top level: one data word in, one word per line slot out.
//
// Each data word accepted on the req_ channel is sent as a frame of line slots, one
// rsp_ word per slot: preamble_pairs high/low pairs, sync_slots high slots, one low
// slot, then the eight data bits least significant first, Manchester coded (a one is
// high then low, a zero low then high). rsp_last_slot marks the final slot of the
// frame, after which the line is understood to rest low. A frame holds
// 2*preamble_pairs + sync_slots + 17 slots, 33 with the reset settings. The frame
// sequencer emits one slot per cycle into an output register while that register is
// free, that is empty or being taken with rsp_ready. The sequencer takes the next word
// as soon as the final slot sits in the output register, even while that slot still
// waits to be taken.
// Settings are written on the csr_ port (index 0: preamble_pairs, index 1:
// sync_slots, low four bits of the data kept, other indexes ignored) while no frame
// is in flight; the port is always ready.
module manchester_frame_transmitter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mft_pkg::CsrIndexW-1:0] csr_index,
   input  logic [mft_pkg::CsrDataW-1:0]  csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mft_pkg::DataW-1:0]     req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_line_level,
   output logic                          rsp_last_slot
);
   import mft_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Settings registers accept a write in any cycle.
   assign csr_ready = 1'b1;

   // The sequencer walks the frame sections; it only commands the datapath.
   mft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   // The datapath holds the settings, the slot counter, the data shifter and the
   // output register.
   mft_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_level (rsp_line_level),
      .rsp_last_slot  (rsp_last_slot),
      .cmd_i          (cmd),
      .status_o       (status)
   );

endmodule

// ----- hw/rtl/mft_ctrl.sv -----
// Frame sequencer state machine of the Manchester frame transmitter.
`include "manchester_frame_transmitter_defines.svh"

module mft_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mft_pkg::status_type status_i,
   output mft_pkg::cmd_type    cmd_o
);
   import mft_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PRE_HI = 7'b0000010,
      ST_PRE_LO = 7'b0000100,
      ST_SYNC   = 7'b0001000,
      ST_GAP    = 7'b0010000,
      ST_DATA_A = 7'b0100000,
      ST_DATA_B = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd_o.load_byte = 1'b0;
      cmd_o.cnt_load  = 1'b0;
      cmd_o.cnt_src   = CNT_PRE;
      cmd_o.cnt_dec   = 1'b0;
      cmd_o.shift     = 1'b0;
      cmd_o.emit      = 1'b0;
      cmd_o.lvl_src   = LVL_LOW;
      cmd_o.last      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.load_byte = 1'b1;
               cmd_o.cnt_load  = 1'b1;
               if (!status_i.pre_zero) begin
                  cmd_o.cnt_src = CNT_PRE;
                  state_in      = ST_PRE_HI;
               end else if (!status_i.sync_zero) begin
                  cmd_o.cnt_src = CNT_SYNC;
                  state_in      = ST_SYNC;
               end else begin
                  state_in = ST_GAP;
               end
            end
         end
         ST_PRE_HI: begin
            if (status_i.out_free) begin
               cmd_o.emit    = 1'b1;
               cmd_o.lvl_src = LVL_HIGH;
               state_in      = ST_PRE_LO;
            end
         end
         ST_PRE_LO: begin
            if (status_i.out_free) begin
               cmd_o.emit    = 1'b1;
               cmd_o.lvl_src = LVL_LOW;
               if (!status_i.cnt_last) begin
                  cmd_o.cnt_dec = 1'b1;
                  state_in      = ST_PRE_HI;
               end else if (!status_i.sync_zero) begin
                  cmd_o.cnt_load = 1'b1;
                  cmd_o.cnt_src  = CNT_SYNC;
                  state_in       = ST_SYNC;
               end else begin
                  state_in = ST_GAP;
               end
            end
         end
         ST_SYNC: begin
            if (status_i.out_free) begin
               cmd_o.emit    = 1'b1;
               cmd_o.lvl_src = LVL_HIGH;
               if (status_i.cnt_last) begin
                  state_in = ST_GAP;
               end else begin
                  cmd_o.cnt_dec = 1'b1;
               end
            end
         end
         ST_GAP: begin
            if (status_i.out_free) begin
               cmd_o.emit     = 1'b1;
               cmd_o.lvl_src  = LVL_LOW;
               cmd_o.cnt_load = 1'b1;
               cmd_o.cnt_src  = CNT_BITS;
               state_in       = ST_DATA_A;
            end
         end
         ST_DATA_A: begin
            if (status_i.out_free) begin
               cmd_o.emit    = 1'b1;
               cmd_o.lvl_src = LVL_BIT;
               state_in      = ST_DATA_B;
            end
         end
         ST_DATA_B: begin
            if (status_i.out_free) begin
               cmd_o.emit    = 1'b1;
               cmd_o.lvl_src = LVL_NBIT;
               cmd_o.shift   = 1'b1;
               if (status_i.cnt_last) begin
                  cmd_o.last = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd_o.cnt_dec = 1'b1;
                  state_in      = ST_DATA_A;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The end-of-frame flag is raised only on the second half of the final bit.
   `MFT_ASSERT_NEXT(a_last_ends_frame, clock, reset, cmd_o.last, state_ff == ST_IDLE)
   // Nothing is loaded into the output register unless it is free.
   `MFT_ASSERT_NOW(a_emit_needs_room, clock, reset, cmd_o.emit, status_i.out_free)
   // A word taken at the input always starts a frame.
   `MFT_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff != ST_IDLE)
   // The gap slot always leads into the first data half.
   `MFT_ASSERT_NEXT(a_gap_to_data, clock, reset, (state_ff == ST_GAP) && status_i.out_free,
      state_ff == ST_DATA_A)

endmodule

// ----- hw/rtl/mft_dp.sv -----
// Datapath of the Manchester frame transmitter: settings, counter, shifter, output.
module mft_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [mft_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [mft_pkg::CsrDataW-1:0]        csr_data,
   input  logic [mft_pkg::DataW-1:0]           req_data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_line_level,
   output logic                                rsp_last_slot,
   input  mft_pkg::cmd_type                    cmd_i,
   output mft_pkg::status_type                 status_o
);
   import mft_pkg::*;

   logic [CfgW-1:0]  pre_ff,   pre_in;
   logic [CfgW-1:0]  sync_ff,  sync_in;
   logic [CntW-1:0]  cnt_ff,   cnt_in;
   logic [DataW-1:0] shift_ff, shift_in;
   logic             valid_ff, valid_in;
   logic             level_ff, level_in;
   logic             last_ff,  last_in;
   logic             level_sel;

   always_comb begin
      pre_in  = pre_ff;
      sync_in = sync_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PREAMBLE_PAIRS: pre_in  = csr_data[CfgW-1:0];
            CSR_SYNC_SLOTS:     sync_in = csr_data[CfgW-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd_i.cnt_load) begin
         case (cmd_i.cnt_src)
            CNT_PRE:  cnt_in = pre_ff;
            CNT_SYNC: cnt_in = sync_ff;
            CNT_BITS: cnt_in = DataBitCount;
            default:  cnt_in = cnt_ff;
         endcase
      end else if (cmd_i.cnt_dec) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_comb begin
      shift_in = shift_ff;
      if (cmd_i.load_byte) begin
         shift_in = req_data_byte;
      end else if (cmd_i.shift) begin
         shift_in = {1'b0, shift_ff[DataW-1:1]};
      end
   end

   always_comb begin
      case (cmd_i.lvl_src)
         LVL_LOW:  level_sel = 1'b0;
         LVL_HIGH: level_sel = 1'b1;
         LVL_BIT:  level_sel = shift_ff[0];
         LVL_NBIT: level_sel = ~shift_ff[0];
         default:  level_sel = 1'b0;
      endcase
   end

   // Output register: a slot waits here until the consumer takes it.
   assign status_o.out_free  = !valid_ff || rsp_ready;
   assign status_o.cnt_last  = (cnt_ff == CntW'(1));
   assign status_o.pre_zero  = (pre_ff == '0);
   assign status_o.sync_zero = (sync_ff == '0);

   always_comb begin
      valid_in = valid_ff;
      level_in = level_ff;
      last_in  = last_ff;
      if (cmd_i.emit) begin
         valid_in = 1'b1;
         level_in = level_sel;
         last_in  = cmd_i.last;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff   <= PreamblePairsReset;
         sync_ff  <= SyncSlotsReset;
         valid_ff <= 1'b0;
      end else begin
         pre_ff   <= pre_in;
         sync_ff  <= sync_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      level_ff <= level_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_line_level = level_ff;
   assign rsp_last_slot  = last_ff;

endmodule
